// ===== rtl/edd_pkg.sv =====
// Shared constants and types for the entropy group detector.
package edd_pkg;
    localparam int ADDRESS_SPAN = 256;
    localparam int ADDR_W = $clog2(ADDRESS_SPAN);
    localparam int DIST_W = ((ADDR_W > 8) ? ADDR_W : 8) + 1;
    localparam int DVD_W = 48;
    localparam int DVS_W = 32;
    localparam logic [16:0] PROB_ONE = 17'd65536;
    localparam logic [15:0] SCORE_MAX = 16'hFFFF;
    localparam logic [11:0] ENT_MAX = 12'hFFF;

    typedef enum logic [1:0] {
        CFG_DIST      = 2'd0,
        CFG_ENT_THR   = 2'd1,
        CFG_SCORE_THR = 2'd2,
        CFG_INIT_REF  = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;
endpackage

// ===== rtl/entropy_group_ddos_detector_unit.sv =====
// Top level of the entropy group detector: packet sequencer, group tables and result word.
// Per word it scans the join window, runs up to two divisions (share, then score) and sums
// the entropy term of every existing group; when entropy is low it also copies each group's
// current share into its reference. in_ready is low for that whole time, so the block takes
// one word at a time on one shared divider and multiplier.
// Asynchronous active-low reset clears groups, counts and state and loads config defaults.
module entropy_group_ddos_detector_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  source_address,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  group_key,
    output logic        group_formed,
    output logic [11:0] entropy_value,
    output logic        entropy_low,
    output logic [15:0] group_score,
    output logic        attack_flag,
    output logic [8:0]  active_group_count,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [16:0] cfg_data
);
    import edd_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SRCH,
        S_HRD,
        S_PDIV,
        S_PWAIT,
        S_CWR,
        S_SWAIT,
        S_ERD,
        S_EGO,
        S_EWAIT,
        S_CMP,
        S_CRD,
        S_CWB,
        S_OUT
    } seq_state_t;

    seq_state_t              state_reg;
    logic [7:0]              dist_cfg_reg;
    logic [11:0]             ent_thr_reg;
    logic [15:0]             score_thr_reg;
    logic [16:0]             init_ref_reg;
    logic [ADDRESS_SPAN-1:0] present_reg;
    logic [31:0]             msg_total_reg;
    logic [8:0]              group_total_reg;
    logic [ADDR_W-1:0]       addr_reg;
    logic [ADDR_W-1:0]       k_reg;
    logic [ADDR_W-1:0]       hi_reg;
    logic [ADDR_W-1:0]       best_reg;
    logic [DIST_W-1:0]       bestd_reg;
    logic                    found_reg;
    logic [ADDR_W-1:0]       key_reg;
    logic                    formed_reg;
    logic [16:0]             ref_val_reg;
    logic [16:0]             cur_val_reg;
    logic [15:0]             score_reg;
    logic [ADDR_W-1:0]       idx_reg;
    logic [11:0]             sum_reg;
    logic                    low_reg;
    logic                    attack_reg;
    logic                    out_valid_reg;
    logic [7:0]              key_out_reg;
    logic                    formed_out_reg;
    logic [11:0]             ent_out_reg;
    logic                    low_out_reg;
    logic [15:0]             score_out_reg;
    logic                    attack_out_reg;
    logic [8:0]              count_out_reg;

    logic [DIST_W-1:0] src_ext;
    logic [ADDR_W-1:0] addr_c;
    logic [DIST_W-1:0] a_ext;
    logic [DIST_W-1:0] d_ext;
    logic [DIST_W-1:0] lo_c;
    logic [DIST_W:0]   hi_sum;
    logic [ADDR_W-1:0] hi_c;
    logic [ADDR_W-1:0] dist_c;
    logic [ADDR_W-1:0] key_sel;
    logic              last_idx;
    logic [31:0]       hits_rd;
    logic [31:0]       hits_new;
    logic [16:0]       cur_rd;
    logic [16:0]       ref_rd;
    logic              hits_we;
    logic              cur_we;
    logic              ref_we;
    logic [ADDR_W-1:0] hits_addr;
    logic [ADDR_W-1:0] cur_addr;
    logic [ADDR_W-1:0] ref_addr;
    logic [16:0]       ref_wdata;
    logic              div_start;
    logic [DVD_W-1:0]  div_dividend;
    logic [DVS_W-1:0]  div_divisor;
    logic [DVD_W-1:0]  div_quot;
    unit_stat_t        div_stat;
    logic              ent_start;
    logic [12:0]       ent_term;
    unit_stat_t        ent_stat;
    logic [13:0]       sum_add;
    logic              out_free;

    assign src_ext = DIST_W'(source_address);
    assign addr_c = (src_ext > DIST_W'(ADDRESS_SPAN - 1)) ? ADDR_W'(ADDRESS_SPAN - 1)
                                                         : ADDR_W'(src_ext);
    assign a_ext = DIST_W'(addr_c);
    assign d_ext = DIST_W'(dist_cfg_reg);
    assign lo_c = (a_ext >= d_ext) ? (a_ext - d_ext) : '0;
    assign hi_sum = {1'b0, a_ext} + {1'b0, d_ext};
    assign hi_c = (hi_sum > (DIST_W + 1)'(ADDRESS_SPAN - 1)) ? ADDR_W'(ADDRESS_SPAN - 1)
                                                           : ADDR_W'(hi_sum);
    assign dist_c = (k_reg > addr_reg) ? (k_reg - addr_reg) : (addr_reg - k_reg);
    assign key_sel = found_reg ? best_reg : addr_reg;
    assign last_idx = idx_reg == ADDR_W'(ADDRESS_SPAN - 1);
    assign hits_new = formed_reg ? 32'd1 : (hits_rd + 32'd1);
    assign sum_add = 14'(sum_reg) + 14'(ent_term);
    assign out_free = !out_valid_reg || out_ready;

    assign hits_we = state_reg == S_PDIV;
    assign hits_addr = (state_reg == S_HRD) ? key_sel : key_reg;
    assign cur_we = state_reg == S_CWR;
    assign cur_addr = (state_reg == S_CWR) ? key_reg : idx_reg;
    assign ref_we = ((state_reg == S_PDIV) && formed_reg)
                    || ((state_reg == S_CWB) && present_reg[idx_reg]);
    assign ref_addr = (state_reg == S_CWB) ? idx_reg
                    : ((state_reg == S_HRD) ? key_sel : key_reg);
    assign ref_wdata = (state_reg == S_CWB) ? cur_rd : init_ref_reg;

    assign div_start = ((state_reg == S_PDIV) && (msg_total_reg != '0))
                       || ((state_reg == S_CWR) && (ref_val_reg != '0));
    assign div_dividend = (state_reg == S_PDIV) ? {hits_new, 16'd0}
                                                : DVD_W'({cur_val_reg, 8'd0});
    assign div_divisor = (state_reg == S_PDIV) ? msg_total_reg : DVS_W'(ref_val_reg);
    assign ent_start = (state_reg == S_EGO) && present_reg[idx_reg];

    edd_ram #(.WIDTH(32), .DEPTH(ADDRESS_SPAN)) u_hits_ram (
        .clk   (clk),
        .we    (hits_we),
        .addr  (hits_addr),
        .wdata (hits_new),
        .rdata (hits_rd)
    );

    edd_ram #(.WIDTH(17), .DEPTH(ADDRESS_SPAN)) u_cur_ram (
        .clk   (clk),
        .we    (cur_we),
        .addr  (cur_addr),
        .wdata (cur_val_reg),
        .rdata (cur_rd)
    );

    edd_ram #(.WIDTH(17), .DEPTH(ADDRESS_SPAN)) u_ref_ram (
        .clk   (clk),
        .we    (ref_we),
        .addr  (ref_addr),
        .wdata (ref_wdata),
        .rdata (ref_rd)
    );

    edd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .stat     (div_stat),
        .quotient (div_quot)
    );

    edd_ent u_ent (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ent_start),
        .p     (cur_rd),
        .stat  (ent_stat),
        .term  (ent_term)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dist_cfg_reg <= 8'd8;
            ent_thr_reg <= 12'd1024;
            score_thr_reg <= 16'd512;
            init_ref_reg <= 17'd655;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_DIST:      dist_cfg_reg <= cfg_data[7:0];
                CFG_ENT_THR:   ent_thr_reg <= cfg_data[11:0];
                CFG_SCORE_THR: score_thr_reg <= cfg_data[15:0];
                CFG_INIT_REF:  init_ref_reg <= cfg_data;
                default:       dist_cfg_reg <= dist_cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            present_reg <= '0;
            msg_total_reg <= '0;
            group_total_reg <= '0;
            addr_reg <= '0;
            k_reg <= '0;
            hi_reg <= '0;
            best_reg <= '0;
            bestd_reg <= '0;
            found_reg <= 1'b0;
            key_reg <= '0;
            formed_reg <= 1'b0;
            ref_val_reg <= '0;
            cur_val_reg <= '0;
            score_reg <= '0;
            idx_reg <= '0;
            sum_reg <= '0;
            low_reg <= 1'b0;
            attack_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            key_out_reg <= '0;
            formed_out_reg <= 1'b0;
            ent_out_reg <= '0;
            low_out_reg <= 1'b0;
            score_out_reg <= '0;
            attack_out_reg <= 1'b0;
            count_out_reg <= '0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        addr_reg <= addr_c;
                        msg_total_reg <= msg_total_reg + 32'd1;
                        k_reg <= ADDR_W'(lo_c);
                        hi_reg <= hi_c;
                        bestd_reg <= d_ext + DIST_W'(1);
                        found_reg <= 1'b0;
                        state_reg <= S_SRCH;
                    end
                end
                S_SRCH:
                begin
                    if (present_reg[k_reg] && (DIST_W'(dist_c) < bestd_reg))
                    begin
                        bestd_reg <= DIST_W'(dist_c);
                        best_reg <= k_reg;
                        found_reg <= 1'b1;
                    end
                    if (k_reg == hi_reg)
                    begin
                        state_reg <= S_HRD;
                    end
                    else
                    begin
                        k_reg <= k_reg + ADDR_W'(1);
                    end
                end
                S_HRD:
                begin
                    key_reg <= key_sel;
                    formed_reg <= !found_reg;
                    state_reg <= S_PDIV;
                end
                S_PDIV:
                begin
                    ref_val_reg <= formed_reg ? init_ref_reg : ref_rd;
                    if (formed_reg)
                    begin
                        present_reg[key_reg] <= 1'b1;
                        group_total_reg <= group_total_reg + 9'd1;
                    end
                    if (msg_total_reg == '0)
                    begin
                        cur_val_reg <= PROB_ONE;
                        state_reg <= S_CWR;
                    end
                    else
                    begin
                        state_reg <= S_PWAIT;
                    end
                end
                S_PWAIT:
                begin
                    if (div_stat.done)
                    begin
                        cur_val_reg <= (div_quot > DVD_W'(PROB_ONE)) ? PROB_ONE
                                                                     : div_quot[16:0];
                        state_reg <= S_CWR;
                    end
                end
                S_CWR:
                begin
                    idx_reg <= '0;
                    sum_reg <= '0;
                    if (ref_val_reg == '0)
                    begin
                        score_reg <= SCORE_MAX;
                        state_reg <= S_ERD;
                    end
                    else
                    begin
                        state_reg <= S_SWAIT;
                    end
                end
                S_SWAIT:
                begin
                    if (div_stat.done)
                    begin
                        score_reg <= (div_quot > DVD_W'(SCORE_MAX)) ? SCORE_MAX
                                                                    : div_quot[15:0];
                        state_reg <= S_ERD;
                    end
                end
                S_ERD:
                begin
                    state_reg <= S_EGO;
                end
                S_EGO:
                begin
                    if (present_reg[idx_reg])
                    begin
                        state_reg <= S_EWAIT;
                    end
                    else if (last_idx)
                    begin
                        state_reg <= S_CMP;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + ADDR_W'(1);
                        state_reg <= S_ERD;
                    end
                end
                S_EWAIT:
                begin
                    if (ent_stat.done)
                    begin
                        sum_reg <= (sum_add > 14'(ENT_MAX)) ? ENT_MAX : sum_add[11:0];
                        if (last_idx)
                        begin
                            state_reg <= S_CMP;
                        end
                        else
                        begin
                            idx_reg <= idx_reg + ADDR_W'(1);
                            state_reg <= S_ERD;
                        end
                    end
                end
                S_CMP:
                begin
                    low_reg <= sum_reg < ent_thr_reg;
                    attack_reg <= !(sum_reg < ent_thr_reg) && (score_reg >= score_thr_reg);
                    idx_reg <= '0;
                    state_reg <= (sum_reg < ent_thr_reg) ? S_CRD : S_OUT;
                end
                S_CRD:
                begin
                    state_reg <= S_CWB;
                end
                S_CWB:
                begin
                    if (last_idx)
                    begin
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + ADDR_W'(1);
                        state_reg <= S_CRD;
                    end
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        key_out_reg <= 8'(key_reg);
                        formed_out_reg <= formed_reg;
                        ent_out_reg <= sum_reg;
                        low_out_reg <= low_reg;
                        score_out_reg <= score_reg;
                        attack_out_reg <= attack_reg;
                        count_out_reg <= group_total_reg;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_ready = state_reg == S_IDLE;
    assign out_valid = out_valid_reg;
    assign group_key = key_out_reg;
    assign group_formed = formed_out_reg;
    assign entropy_value = ent_out_reg;
    assign entropy_low = low_out_reg;
    assign group_score = score_out_reg;
    assign attack_flag = attack_out_reg;
    assign active_group_count = count_out_reg;

`ifndef SYNTH
    assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !div_stat.busy && !ent_stat.busy)
        else $error("Arithmetic unit busy while the block takes a new word.");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("Block still ready right after taking a word.");

    assert property (@(posedge clk) disable iff (!rst_n)
        ent_start |-> !div_stat.busy)
        else $error("Entropy unit started while a division is running.");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && attack_flag |-> !entropy_low)
        else $error("Attack flagged on a word with low entropy.");
`endif
endmodule

// ===== rtl/edd_ram.sv =====
// Generic single-port RAM with registered read data.
module edd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// ===== rtl/edd_div.sv =====
// Restoring divider that produces one quotient bit per cycle.
module edd_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [edd_pkg::DVD_W-1:0] dividend,
    input  logic [edd_pkg::DVS_W-1:0] divisor,
    output edd_pkg::unit_stat_t       stat,
    output logic [edd_pkg::DVD_W-1:0] quotient
);
    import edd_pkg::*;

    logic             busy_reg;
    logic             done_reg;
    logic [5:0]       cnt_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [DVD_W-1:0] quot_reg;
    logic [DVS_W:0]   rem_sh;
    logic [DVS_W:0]   diff;
    logic             ge;

    assign rem_sh = {rem_reg, quot_reg[DVD_W-1]};
    assign ge = rem_sh >= {1'b0, dvs_reg};
    assign diff = rem_sh - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'(DVD_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dvs_reg <= divisor;
            quot_reg <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
            quot_reg <= {quot_reg[DVD_W-2:0], ge};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient = quot_reg;
endmodule

// ===== rtl/edd_ent.sv =====
// Entropy term unit: log2 by repeated squaring on one shared multiplier.
module edd_ent (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [16:0]         p,
    output edd_pkg::unit_stat_t stat,
    output logic [12:0]         term
);
    import edd_pkg::*;

    typedef enum logic [2:0] {
        E_IDLE,
        E_NORM,
        E_MUL,
        E_ACC,
        E_TMUL,
        E_TOUT
    } ent_state_t;

    ent_state_t  state_reg;
    logic [16:0] p_reg;
    logic [16:0] m_reg;
    logic [4:0]  n_reg;
    logic [7:0]  frac_reg;
    logic [2:0]  cnt_reg;
    logic [33:0] prod_reg;
    logic [12:0] term_reg;
    logic        done_reg;
    logic [4:0]  top_n;
    logic [31:0] shifted;
    logic [18:0] sq;
    logic [12:0] l_val;
    logic [12:0] l_inv;
    logic [16:0] mul_a;
    logic [16:0] mul_b;

    always_comb
    begin
        top_n = '0;
        for (int b = 0; b < 17; b++)
        begin
            if (p_reg[b])
            begin
                top_n = 5'(b);
            end
        end
    end

    assign shifted = {p_reg[16:0], 15'd0} >> top_n;
    assign sq = prod_reg[33:15];
    assign l_val = {n_reg, frac_reg};
    assign l_inv = 13'd4096 - l_val;
    assign mul_a = (state_reg == E_TMUL) ? p_reg : m_reg;
    assign mul_b = (state_reg == E_TMUL) ? {4'd0, l_inv} : m_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= E_IDLE;
            done_reg <= 1'b0;
            p_reg <= '0;
            m_reg <= '0;
            n_reg <= '0;
            frac_reg <= '0;
            cnt_reg <= '0;
            prod_reg <= '0;
            term_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                E_IDLE:
                begin
                    if (start)
                    begin
                        p_reg <= p;
                        state_reg <= E_NORM;
                    end
                end
                E_NORM:
                begin
                    if (p_reg == '0)
                    begin
                        term_reg <= '0;
                        done_reg <= 1'b1;
                        state_reg <= E_IDLE;
                    end
                    else
                    begin
                        n_reg <= top_n;
                        m_reg <= shifted[16:0];
                        frac_reg <= '0;
                        cnt_reg <= '0;
                        state_reg <= E_MUL;
                    end
                end
                E_MUL:
                begin
                    prod_reg <= 34'(mul_a) * 34'(mul_b);
                    state_reg <= E_ACC;
                end
                E_ACC:
                begin
                    if (sq >= 19'd65536)
                    begin
                        m_reg <= sq[17:1];
                        frac_reg <= {frac_reg[6:0], 1'b1};
                    end
                    else
                    begin
                        m_reg <= sq[16:0];
                        frac_reg <= {frac_reg[6:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg + 3'd1;
                    state_reg <= (cnt_reg == 3'd7) ? E_TMUL : E_MUL;
                end
                E_TMUL:
                begin
                    prod_reg <= 34'(mul_a) * 34'(mul_b);
                    state_reg <= E_TOUT;
                end
                E_TOUT:
                begin
                    term_reg <= prod_reg[28:16];
                    done_reg <= 1'b1;
                    state_reg <= E_IDLE;
                end
                default:
                begin
                    state_reg <= E_IDLE;
                end
            endcase
        end
    end

    assign stat.busy = state_reg != E_IDLE;
    assign stat.done = done_reg;
    assign term = term_reg;
endmodule

// ===== sim/tb_top.sv =====
// Testbench for the entropy group detector: directed and random packets checked against a predictor.
`timescale 1ns / 100ps
module tb_top;
    import edd_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  source_address = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  group_key;
    logic        group_formed;
    logic [11:0] entropy_value;
    logic        entropy_low;
    logic [15:0] group_score;
    logic        attack_flag;
    logic [8:0]  active_group_count;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [16:0] cfg_data = '0;

    typedef struct packed {
        logic [7:0]  key;
        logic        formed;
        logic [11:0] ent;
        logic        low;
        logic [15:0] score;
        logic        attack;
        logic [8:0]  count;
    } verdict_t;

    verdict_t    verdict_q[$];
    int          error_count = 0;
    int          packets_sent = 0;
    int          verdicts_seen = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    bit          hold_off = 1'b0;
    longint      cycle_count = 0;

    logic [7:0]  join_dist;
    logic [11:0] ent_thr;
    logic [15:0] score_thr;
    logic [16:0] init_ref;
    bit          present[ADDRESS_SPAN];
    logic [31:0] hits[ADDRESS_SPAN];
    logic [16:0] cur_p[ADDRESS_SPAN];
    logic [16:0] ref_p[ADDRESS_SPAN];
    logic [15:0] score_mem[ADDRESS_SPAN];
    logic [31:0] msg_total;
    logic [8:0]  grp_total;

    entropy_group_ddos_detector_unit DUT (.*);

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 64'd40000000)
        begin
            $display("tb_top: errors");
            $finish;
        end
    end

    function automatic logic [16:0] share(logic [31:0] h, logic [31:0] t);
        logic [63:0] p;
        if (t == 0)
            return PROB_ONE;
        p = {h, 16'd0} / t;
        return (p > 65536) ? PROB_ONE : p[16:0];
    endfunction

    function automatic logic [15:0] ratio(logic [16:0] c, logic [16:0] r);
        logic [63:0] s;
        if (r == 0)
            return SCORE_MAX;
        s = {c, 8'd0} / r;
        return (s > 65535) ? SCORE_MAX : s[15:0];
    endfunction

    function automatic logic [31:0] info_term(logic [16:0] p);
        int          n;
        logic [31:0] fr;
        logic [63:0] m;
        logic [63:0] prod;
        if (p == 0)
            return 0;
        n = 0;
        while (n < 16 && (p >> (n + 1)) != 0)
            n++;
        m = (n <= 15) ? (64'(p) << (15 - n)) : (64'(p) >> 1);
        fr = 0;
        for (int i = 0; i < 8; i++)
        begin
            m = (m * m) >> 15;
            fr = fr << 1;
            if (m >= 65536)
            begin
                m = m >> 1;
                fr = fr | 1;
            end
        end
        prod = 64'(p) * 64'(4096 - (n * 256 + fr));
        return prod[47:16];
    endfunction

    function automatic verdict_t classify_packet(logic [7:0] addr);
        verdict_t    v;
        int          lo;
        int          hi;
        int          best;
        int          bestd;
        int          gap;
        int          k;
        logic [31:0] sum;
        v = '0;
        msg_total = msg_total + 1;
        lo = int'(addr) - int'(join_dist);
        if (lo < 0)
            lo = 0;
        hi = int'(addr) + int'(join_dist);
        if (hi > ADDRESS_SPAN - 1)
            hi = ADDRESS_SPAN - 1;
        best = -1;
        bestd = int'(join_dist) + 1;
        for (int j = lo; j <= hi; j++)
        begin
            if (present[j])
            begin
                gap = (j > int'(addr)) ? j - int'(addr) : int'(addr) - j;
                if (gap < bestd)
                begin
                    bestd = gap;
                    best = j;
                end
            end
        end
        if (best >= 0)
        begin
            k = best;
            hits[k] = hits[k] + 1;
            cur_p[k] = share(hits[k], msg_total);
        end
        else
        begin
            k = int'(addr);
            v.formed = 1'b1;
            present[k] = 1'b1;
            hits[k] = 1;
            cur_p[k] = share(1, msg_total);
            ref_p[k] = init_ref;
            score_mem[k] = ratio(cur_p[k], ref_p[k]);
            grp_total = grp_total + 1;
        end
        sum = 0;
        for (int j = 0; j < ADDRESS_SPAN; j++)
            if (present[j])
                sum = sum + info_term(cur_p[j]);
        v.ent = (sum > 4095) ? ENT_MAX : sum[11:0];
        v.low = v.ent < ent_thr;
        if (v.low)
        begin
            for (int j = 0; j < ADDRESS_SPAN; j++)
            begin
                if (present[j])
                begin
                    score_mem[j] = ratio(cur_p[j], ref_p[j]);
                    ref_p[j] = cur_p[j];
                end
            end
        end
        else
        begin
            score_mem[k] = ratio(cur_p[k], ref_p[k]);
            v.attack = score_mem[k] >= score_thr;
        end
        v.key = 8'(k);
        v.score = score_mem[k];
        v.count = grp_total;
        return v;
    endfunction

    task automatic send_packet(input logic [7:0] addr);
        while ($urandom_range(99) < send_idle_pct)
            @(posedge clk);
        verdict_q.push_back(classify_packet(addr));
        in_valid <= 1'b1;
        source_address <= addr;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        packets_sent++;
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [16:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_DIST:      join_dist = val[7:0];
            CFG_ENT_THR:   ent_thr = val[11:0];
            CFG_SCORE_THR: score_thr = val[15:0];
            default:       init_ref = val;
        endcase
        @(posedge clk);
    endtask

    task automatic wait_idle();
        while (verdict_q.size() != 0)
            @(posedge clk);
        repeat (20)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        verdict_t e;
        if (out_valid && out_ready)
        begin
            verdicts_seen++;
            if (verdict_q.size() == 0)
            begin
                $error("unexpected word key=%0d", group_key);
                error_count++;
            end
            else
            begin
                e = verdict_q.pop_front();
                if (group_key !== e.key)
                begin
                    $error("group_key exp %0d got %0d", e.key, group_key);
                    error_count++;
                end
                if (group_formed !== e.formed)
                begin
                    $error("group_formed exp %0d got %0d", e.formed, group_formed);
                    error_count++;
                end
                if (entropy_value !== e.ent)
                begin
                    $error("entropy_value exp %0d got %0d", e.ent, entropy_value);
                    error_count++;
                end
                if (entropy_low !== e.low)
                begin
                    $error("entropy_low exp %0d got %0d", e.low, entropy_low);
                    error_count++;
                end
                if (group_score !== e.score)
                begin
                    $error("group_score exp %0d got %0d", e.score, group_score);
                    error_count++;
                end
                if (attack_flag !== e.attack)
                begin
                    $error("attack_flag exp %0d got %0d", e.attack, attack_flag);
                    error_count++;
                end
                if (active_group_count !== e.count)
                begin
                    $error("active_group_count exp %0d got %0d", e.count,
                           active_group_count);
                    error_count++;
                end
            end
        end
        out_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic test_directed();
        send_packet(8'd0);
        send_packet(8'd255);
        send_packet(8'd4);
        send_packet(8'd8);
        send_packet(8'd9);
        send_packet(8'd128);
        send_packet(8'd124);
        send_packet(8'd132);
        send_packet(8'd250);
        send_packet(8'd255);
        wait_idle();
        write_reg(CFG_DIST, 17'd0);
        write_reg(CFG_SCORE_THR, 17'd0);
        write_reg(CFG_INIT_REF, 17'd0);
        send_packet(8'd1);
        send_packet(8'd1);
        send_packet(8'd2);
        wait_idle();
        write_reg(CFG_DIST, 17'd255);
        write_reg(CFG_ENT_THR, 17'd2048);
        write_reg(CFG_INIT_REF, 17'd65536);
        send_packet(8'd77);
        send_packet(8'd200);
        send_packet(8'd170);
        wait_idle();
        write_reg(CFG_ENT_THR, 17'd0);
        write_reg(CFG_SCORE_THR, 17'd65535);
        send_packet(8'd33);
        send_packet(8'd90);
        wait_idle();
    endtask

    task automatic test_random_phase(input int n, input int idle, input int stall);
        logic [7:0] hot;
        send_idle_pct = idle;
        recv_stall_pct = stall;
        hot = 8'($urandom);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(99) < 70)
                send_packet(8'(hot + $urandom_range(6) - 3));
            else
                send_packet(8'($urandom));
        end
        wait_idle();
        write_reg(CFG_DIST, 17'($urandom_range(2) == 0 ? $urandom_range(255)
                                                      : $urandom_range(12)));
        write_reg(CFG_ENT_THR, 17'($urandom_range(2048)));
        write_reg(CFG_SCORE_THR, 17'($urandom_range(2) == 0 ? $urandom_range(65535)
                                                           : $urandom_range(1024)));
        write_reg(CFG_INIT_REF, 17'($urandom_range(65536, 1)));
    endtask

    task automatic test_backpressure();
        fork
            begin
                hold_off = 1'b1;
                repeat (30000)
                    @(posedge clk);
                hold_off = 1'b0;
            end
            begin
                for (int i = 0; i < 6; i++)
                    send_packet(8'($urandom));
            end
        join
        wait_idle();
    endtask

    initial
    begin
        join_dist = 8;
        ent_thr = 1024;
        score_thr = 512;
        init_ref = 655;
        for (int j = 0; j < ADDRESS_SPAN; j++)
        begin
            present[j] = 1'b0;
            hits[j] = 0;
            cur_p[j] = 0;
            ref_p[j] = 0;
            score_mem[j] = 0;
        end
        msg_total = 0;
        grp_total = 0;
        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_phase(130, 0, 0);
        test_random_phase(130, 68, 0);
        test_random_phase(130, 0, 68);
        test_random_phase(130, 12, 12);
        test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        wait_idle();
        repeat (2000)
            @(posedge clk);
        $display("Sent %0d packets, checked %0d words, over several register settings",
                 packets_sent, verdicts_seen);
        $display("and idle, stall and long hold-off phases.");
        if (error_count == 0 && verdict_q.size() == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end
endmodule
